// File: hdl/lsc_pkg.sv
// lsc_pkg: shared types and constants for the line splitter
// result kinds, character codes, result and bundle structs
// no dependencies
package lsc_pkg;

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam logic [15:0] LIMIT_RESET = 16'd256;
	localparam logic [31:0] POS_MAX     = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		KIND_CONTENT  = 3'd0,
		KIND_LINE_END = 3'd1,
		KIND_BREAK    = 3'd2,
		KIND_FINAL    = 3'd3,
		KIND_EOD      = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic        starts_line;
		logic [31:0] fragment_offset;
		logic        last_of_run;
	} result_t;

	// results caused by one item: one or two
	typedef struct packed {
		logic    valid;
		logic    two;
		result_t r0;
		result_t r1;
	} bundle_t;

endpackage

// File: hdl/lsc_if.sv
// lsc_if: valid/ready channels of the line splitter
// byte channel in, result channel out
// no dependencies
interface lsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_data;

	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface lsc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  out_byte;
	logic        starts_line;
	logic [31:0] fragment_offset;
	logic        last_of_run;

	modport source (output valid, output kind, output out_byte, output starts_line,
		output fragment_offset, output last_of_run, input ready);
	modport sink (input valid, input kind, input out_byte, input starts_line,
		input fragment_offset, input last_of_run, output ready);
endinterface

// File: hdl/lsc_core.sv
// lsc_core: line and fragment state, builds the results of one item
// depends on lsc_pkg and lsc_in_if
module lsc_core import lsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        line_limit_we,
	input  logic [15:0] line_limit_wdata,
	lsc_in_if.sink      stream,
	input  logic        q_ready,
	output bundle_t     push
);

	logic [15:0] cap_q;
	logic [15:0] count_q;
	logic        cont_q;
	logic        acr_q;
	logic [31:0] pos_q;
	logic [31:0] frag_q;

	logic [15:0] count_d;
	logic        cont_d;
	logic        acr_d;
	logic [31:0] pos_d;
	logic [31:0] frag_d;
	logic [31:0] pos_inc;
	logic        accept;
	logic        is_eol;
	logic        brk;
	logic        cont1;
	logic [15:0] cnt1;
	logic [31:0] fs;
	result_t     res_content;
	result_t     res_brk;
	result_t     res_eol;
	result_t     res_eod;

	assign stream.ready = q_ready;
	assign accept  = stream.valid & q_ready;
	assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + 32'd1;
	assign is_eol  = (stream.data_byte == CH_CR) || (stream.data_byte == CH_LF);

	always_comb begin
		brk   = (count_q >= cap_q);
		cont1 = brk ? 1'b1 : cont_q;
		cnt1  = brk ? 16'd0 : count_q;
		fs    = (cnt1 == 16'd0) ? pos_q : frag_q;

		res_brk = '{kind: KIND_BREAK, out_byte: 8'd0, starts_line: ~cont_q,
			fragment_offset: frag_q, last_of_run: 1'b0};
		res_content = '{kind: KIND_CONTENT,
			out_byte: (stream.data_byte == CH_NUL) ? CH_SPACE : stream.data_byte,
			starts_line: ~cont1, fragment_offset: fs, last_of_run: 1'b1};
		res_eol = '{kind: KIND_LINE_END, out_byte: CH_CR, starts_line: ~cont_q,
			fragment_offset: (count_q == 16'd0) ? pos_q : frag_q, last_of_run: 1'b1};
		if (count_q != 16'd0) begin
			res_eod = '{kind: KIND_FINAL, out_byte: 8'd0, starts_line: ~cont_q,
				fragment_offset: frag_q, last_of_run: 1'b1};
		end else begin
			res_eod = '{kind: KIND_EOD, out_byte: 8'd0, starts_line: 1'b0,
				fragment_offset: pos_q, last_of_run: 1'b1};
		end

		count_d = count_q;
		cont_d  = cont_q;
		acr_d   = 1'b0;
		pos_d   = pos_q;
		frag_d  = frag_q;
		push    = '{valid: 1'b0, two: 1'b0, r0: res_content, r1: res_content};

		if (stream.end_of_data) begin
			push.valid = accept;
			push.r0    = res_eod;
			if (count_q != 16'd0) begin
				count_d = 16'd0;
				cont_d  = 1'b0;
			end
		end else if (acr_q && (stream.data_byte == CH_LF)) begin
			pos_d = pos_inc;
		end else if (is_eol) begin
			push.valid = accept;
			push.r0    = res_eol;
			count_d    = 16'd0;
			cont_d     = 1'b0;
			acr_d      = (stream.data_byte == CH_CR);
			pos_d      = pos_inc;
			frag_d     = res_eol.fragment_offset;
		end else begin
			push.valid = accept;
			push.two   = brk;
			if (brk) begin
				push.r0 = res_brk;
			end
			count_d = cnt1 + 16'd1;
			cont_d  = cont1;
			pos_d   = pos_inc;
			frag_d  = fs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= LIMIT_RESET - 16'd1;
			count_q <= '0;
			cont_q  <= 1'b0;
			acr_q   <= 1'b0;
			pos_q   <= '0;
			frag_q  <= '0;
		end else begin
			if (line_limit_we) begin
				cap_q <= (line_limit_wdata < 16'd2) ? 16'd1 : line_limit_wdata - 16'd1;
			end
			if (accept) begin
				count_q <= count_d;
				cont_q  <= cont_d;
				acr_q   <= acr_d;
				pos_q   <= pos_d;
				frag_q  <= frag_d;
			end
		end
	end

endmodule

// File: hdl/lsc_out_queue.sv
// lsc_out_queue: two-entry bundle queue, one result per cycle out when ready
// depends on lsc_pkg and lsc_out_if
module lsc_out_queue import lsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  bundle_t  push,
	output logic     q_ready,
	lsc_out_if.source lines
);

	bundle_t     slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        sel_q;
	bundle_t     head;
	result_t     cur;
	logic        take;
	logic        pop;
	logic        do_push;

	assign q_ready = (cnt_q != 2'd2);
	assign head    = slot_q[rd_ptr_q];
	assign cur     = sel_q ? head.r1 : head.r0;
	assign take    = lines.valid & lines.ready;
	assign pop     = take & (~head.two | sel_q);
	assign do_push = push.valid;

	assign lines.valid           = (cnt_q != 2'd0);
	assign lines.kind            = cur.kind;
	assign lines.out_byte        = cur.out_byte;
	assign lines.starts_line     = cur.starts_line;
	assign lines.fragment_offset = cur.fragment_offset;
	assign lines.last_of_run     = cur.last_of_run;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
			sel_q    <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				sel_q    <= 1'b0;
			end else if (take) begin
				sel_q <= 1'b1;
			end
			unique case ({do_push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/line_splitter_crlf_unit.sv
// Line splitter: takes one byte item per cycle (or an end-of-data mark)
// while the result queue has room; gives content, line-end, fragment-break
// and end results. Results are registered into a two-entry result queue; a
// break makes two results, which leave one per cycle when the receiver is
// ready, so breaks slow the byte flow. The user must write line_limit via
// line_limit_we/line_limit_wdata while the block is idle (not enforced).
// depends on lsc_pkg, lsc_if, lsc_core, lsc_out_queue
module line_splitter_crlf_unit import lsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        line_limit_we,
	input  logic [15:0] line_limit_wdata,
	lsc_in_if.sink      stream,
	lsc_out_if.source   lines
);

	bundle_t push;
	logic    q_ready;

	lsc_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.line_limit_we    (line_limit_we),
		.line_limit_wdata (line_limit_wdata),
		.stream           (stream),
		.q_ready          (q_ready),
		.push             (push)
	);

	lsc_out_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.q_ready (q_ready),
		.lines   (lines)
	);

endmodule

// File: tb/tb_line_splitter_crlf_unit.sv
// testbench for line_splitter_crlf_unit: drives byte items and end marks, predicts
// every result in a scoreboard class and checks each one in order of arrival
// depends on lsc_pkg, lsc_if and the line_splitter_crlf_unit rtl
`timescale 1ns / 100ps

module tb_line_splitter_crlf_unit;
	import lsc_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 80;
	localparam int PHASE_ITEMS    = 65;
	localparam int REPORT_LIMIT   = 10;

	class split_tracker;
		logic [15:0] line_limit;
		logic [15:0] content_count;
		logic        continues_line;
		logic        after_cr;
		logic [31:0] byte_pos;
		logic [31:0] frag_start;
		result_t     awaited[$];
		int unsigned fault_count;

		function new();
			line_limit     = LIMIT_RESET;
			content_count  = '0;
			continues_line = 1'b0;
			after_cr       = 1'b0;
			byte_pos       = '0;
			frag_start     = '0;
			fault_count    = 0;
		endfunction

		function void push(kind_t k, logic [7:0] d, logic sl, logic [31:0] off, logic last);
			result_t res;
			res.kind            = k;
			res.out_byte        = d;
			res.starts_line     = sl;
			res.fragment_offset = off;
			res.last_of_run     = last;
			awaited.push_back(res);
		endfunction

		function void advance();
			if (byte_pos != POS_MAX)
				byte_pos = byte_pos + 32'd1;
		endfunction

		function void take_item(logic [7:0] d, logic eod);
			logic [16:0] capacity;
			capacity = (line_limit < 16'd2) ? 17'd1 : {1'b0, line_limit} - 17'd1;
			if (eod) begin
				after_cr = 1'b0;
				if (content_count != 16'd0) begin
					push(KIND_FINAL, 8'd0, !continues_line, frag_start, 1'b1);
					content_count  = '0;
					continues_line = 1'b0;
				end else begin
					push(KIND_EOD, 8'd0, 1'b0, byte_pos, 1'b1);
				end
			end else if (after_cr && d == CH_LF) begin
				after_cr = 1'b0;
				advance();
			end else if (d == CH_CR || d == CH_LF) begin
				if (content_count == 16'd0)
					frag_start = byte_pos;
				push(KIND_LINE_END, CH_CR, !continues_line, frag_start, 1'b1);
				content_count  = '0;
				continues_line = 1'b0;
				after_cr       = (d == CH_CR);
				advance();
			end else begin
				after_cr = 1'b0;
				if ({1'b0, content_count} >= capacity) begin
					push(KIND_BREAK, 8'd0, !continues_line, frag_start, 1'b0);
					continues_line = 1'b1;
					content_count  = '0;
				end
				if (content_count == 16'd0)
					frag_start = byte_pos;
				push(KIND_CONTENT, (d == CH_NUL) ? CH_SPACE : d, !continues_line,
					frag_start, 1'b1);
				content_count = content_count + 16'd1;
				advance();
			end
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected result: kind %0d byte %02h start %0b off %0d last %0b",
						got.kind, got.out_byte, got.starts_line, got.fragment_offset,
						got.last_of_run);
				return;
			end
			want = awaited.pop_front();
			if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
					got.starts_line !== want.starts_line ||
					got.fragment_offset !== want.fragment_offset ||
					got.last_of_run !== want.last_of_run) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT) begin
					$display("mismatch: expected kind %0d byte %02h start %0b off %0d last %0b",
						want.kind, want.out_byte, want.starts_line, want.fragment_offset,
						want.last_of_run);
					$display("          got      kind %0d byte %02h start %0b off %0d last %0b",
						got.kind, got.out_byte, got.starts_line, got.fragment_offset,
						got.last_of_run);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        line_limit_we;
	logic [15:0] line_limit_wdata;

	lsc_in_if  stream_if ();
	lsc_out_if lines_if ();

	line_splitter_crlf_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.line_limit_we    (line_limit_we),
		.line_limit_wdata (line_limit_wdata),
		.stream           (stream_if.sink),
		.lines            (lines_if.source)
	);

	split_tracker tracker = new();

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned items_sent     = 0;
	int unsigned quiet_cycles   = 0;
	bit          hold_request   = 1'b0;
	int unsigned hold_left      = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// result side: random stalls, plus a long hold-off on request
	initial begin
		lines_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				lines_if.ready <= 1'b0;
			end else begin
				lines_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (stream_if.valid && stream_if.ready)
				tracker.take_item(stream_if.data_byte, stream_if.end_of_data);
			if (lines_if.valid && lines_if.ready) begin
				got.kind            = kind_t'(lines_if.kind);
				got.out_byte        = lines_if.out_byte;
				got.starts_line     = lines_if.starts_line;
				got.fragment_offset = lines_if.fragment_offset;
				got.last_of_run     = lines_if.last_of_run;
				tracker.match_result(got);
			end
		end
	end

	always @(posedge clk) begin
		if ((stream_if.valid && stream_if.ready) || (lines_if.valid && lines_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic set_idle(idle_mode_t m);
		case (m)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct  = 81;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct  = 0;
				recv_stall_pct = 81;
			end
			default: begin
				send_idle_pct  = 26;
				recv_stall_pct = 26;
			end
		endcase
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input logic [7:0] d, input logic eod);
		while ($urandom_range(99) < send_idle_pct) begin
			stream_if.valid <= 1'b0;
			@(negedge clk);
		end
		stream_if.valid       <= 1'b1;
		stream_if.data_byte   <= d;
		stream_if.end_of_data <= eod;
		@(posedge clk);
		while (!stream_if.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		stream_if.valid <= 1'b0;
		@(negedge clk);
		while (tracker.awaited.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		wait_drained();
		line_limit_we    <= 1'b1;
		line_limit_wdata <= value;
		@(negedge clk);
		line_limit_we      <= 1'b0;
		tracker.line_limit  = value;
	endtask

	function automatic logic [7:0] pick_content();
		logic [7:0] d;
		if ($urandom_range(9) == 0)
			return CH_NUL;
		do
			d = 8'($urandom_range(255));
		while (d == CH_CR || d == CH_LF);
		return d;
	endfunction

	task automatic send_line(input int unsigned len_max);
		int unsigned len;
		len = $urandom_range(len_max);
		for (int unsigned i = 0; i < len; i++)
			send_item(pick_content(), 1'b0);
		case ($urandom_range(3))
			0: send_item(CH_CR, 1'b0);
			1: send_item(CH_LF, 1'b0);
			2: begin
				send_item(CH_CR, 1'b0);
				send_item(CH_LF, 1'b0);
			end
			default: send_item(8'($urandom_range(255)), 1'b1);
		endcase
	endtask

	task automatic run_phase(input logic [15:0] lim, input idle_mode_t m);
		int unsigned first;
		int unsigned len_max;
		int unsigned pick;
		write_limit(lim);
		set_idle(m);
		len_max = (lim < 16'd40) ? ((lim < 16'd2) ? 4 : 2 * lim + 2) : 30;
		first   = items_sent;
		while (items_sent - first < PHASE_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 75)
				send_line(len_max);
			else if (pick < 92)
				send_item(8'($urandom_range(255)), 1'b0);
			else
				send_item(8'($urandom_range(255)), 1'b1);
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		line_limit_we         = 1'b0;
		line_limit_wdata      = '0;
		stream_if.valid       = 1'b0;
		stream_if.data_byte   = '0;
		stream_if.end_of_data = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset limit: content, nul, line ends, swallowed lf, end marks
		send_item(CH_NUL, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(CH_CR, 1'b0);
		send_item(CH_LF, 1'b0);
		send_item(CH_LF, 1'b0);
		send_item(CH_CR, 1'b0);
		send_item(CH_CR, 1'b0);
		send_item(8'hA5, 1'b1);
		send_item(8'h78, 1'b0);
		send_item(8'h00, 1'b1);
		send_item(CH_CR, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(CH_LF, 1'b0);
		send_item(8'h7E, 1'b0);

		// limit below two holds one byte per fragment, limit three holds two
		write_limit(16'd0);
		send_item(8'h61, 1'b0);
		send_item(8'h62, 1'b0);
		send_item(8'h63, 1'b1);
		write_limit(16'd1);
		send_item(8'h01, 1'b0);
		send_item(CH_NUL, 1'b0);
		send_item(CH_CR, 1'b0);
		write_limit(16'd3);
		send_item(8'h61, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h7F, 1'b0);
		send_item(CH_LF, 1'b0);

		run_phase(16'd2, IDLE_NONE);
		run_phase(16'd5, IDLE_SEND);
		run_phase(16'd1, IDLE_RECV);
		run_phase(16'd0, IDLE_BOTH);
		run_phase(16'd65535, IDLE_NONE);

		// long receiver hold while a line keeps being offered
		set_idle(IDLE_NONE);
		hold_request = 1'b1;
		for (int unsigned i = 0; i < 40; i++)
			send_item(pick_content(), 1'b0);
		send_item(CH_CR, 1'b0);

		run_phase(16'd3, IDLE_RECV);
		run_phase(16'($urandom_range(2, 24)), IDLE_SEND);
		run_phase(16'($urandom_range(2, 24)), IDLE_BOTH);
		run_phase(LIMIT_RESET, IDLE_NONE);
		run_phase(16'd256, IDLE_RECV);

		wait_drained();
		if (tracker.fault_count == 0 && tracker.awaited.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: line_splitter_crlf_unit.f
hdl/lsc_pkg.sv
hdl/lsc_if.sv
hdl/lsc_core.sv
hdl/lsc_out_queue.sv
hdl/line_splitter_crlf_unit.sv
tb/tb_line_splitter_crlf_unit.sv
